### design/dmx_priority_source_merger_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the priority source merger
// Implication checks on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DMX_PRIORITY_SOURCE_MERGER_MACROS_SVH
`define DMX_PRIORITY_SOURCE_MERGER_MACROS_SVH

// same-cycle implication
`define DMX_PSM_ASSERT_NOW(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (prop)) else $error("merger check failed");

// next-cycle implication
`define DMX_PSM_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (prop)) else $error("merger check failed");

`endif

### design/dmx_psm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmx_psm_pkg
// Shared widths, codes and defaults of the priority source merger.
// ----------------------------------------------------------------------------
package dmx_psm_pkg;

    localparam int DEF_SOURCES  = 8;
    localparam int DEF_CHANNELS = 512;

    localparam int CMD_W   = 2;
    localparam int SRCIN_W = 3;
    localparam int CHIN_W  = 9;
    localparam int LVL_W   = 8;
    localparam int PRIO_W  = 8;
    localparam int LEN_W   = 10;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 32;

    localparam logic [PRIO_W-1:0] PRIO_MAX        = 8'd200;
    localparam logic [TIME_W-1:0] TIMEOUT_DEFAULT = 32'd2500;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_COMMIT = 2'd1,
        CMD_READ   = 2'd2,
        CMD_REMOVE = 2'd3
    } t_cmd;

    localparam logic CFG_MODE    = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

endpackage

### design/dmx_psm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmx_psm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dmx_psm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/dmx_priority_source_merger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmx_priority_source_merger
// Per-source DMX frames in RAM, priority scan over source headers and
// HTP/LTP merge into an output frame RAM.
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// input     in         i_valid / o_ready       i_command .. i_now_time
// result    out        o_valid / i_ready       o_read_value .. o_merged_length
// config    in         i_cfg_we                i_cfg_index, i_cfg_data
//
// Write and remove answer straight from idle; read passes through ST_READ for
// the registered output RAM read. Commit scans every source header and, when
// the committing source wins, merges over the one source RAM read port.
// Reset clears headers and lengths at once; no clearing pass.
// A waiting result does not block the next transfer when it is taken.
// ----------------------------------------------------------------------------
module dmx_priority_source_merger #(
    parameter int SOURCES  = dmx_psm_pkg::DEF_SOURCES,
    parameter int CHANNELS = dmx_psm_pkg::DEF_CHANNELS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [dmx_psm_pkg::CMD_W-1:0]     i_command,
    input  logic [dmx_psm_pkg::SRCIN_W-1:0]   i_source_index,
    input  logic [dmx_psm_pkg::CHIN_W-1:0]    i_channel,
    input  logic [dmx_psm_pkg::LVL_W-1:0]     i_value,
    input  logic [dmx_psm_pkg::PRIO_W-1:0]    i_priority_req,
    input  logic [dmx_psm_pkg::LEN_W-1:0]     i_frame_length,
    input  logic [dmx_psm_pkg::TIME_W-1:0]    i_now_time,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [dmx_psm_pkg::LVL_W-1:0]     o_read_value,
    output logic                              o_changed,
    output logic                              o_no_active,
    output logic [dmx_psm_pkg::PRIO_W-1:0]    o_active_level,
    output logic [dmx_psm_pkg::LEN_W-1:0]     o_merged_length,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [dmx_psm_pkg::CFG_W-1:0]     i_cfg_data
);

`include "dmx_priority_source_merger_macros.svh"

    localparam int SW = $clog2(SOURCES);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LW = dmx_psm_pkg::LEN_W;
    localparam int PW = dmx_psm_pkg::PRIO_W;
    localparam int TW = dmx_psm_pkg::TIME_W;
    localparam int VW = dmx_psm_pkg::LVL_W;
    localparam int CHIN_WL = dmx_psm_pkg::CHIN_W;
    localparam int SRC_DEPTH = SOURCES * (2 ** CW);
    localparam int OUT_DEPTH = 2 ** CW;
    localparam logic [SW-1:0] LAST_SRC = SW'(SOURCES - 1);
    localparam logic [LW-1:0] CH_MAX   = LW'(CHANNELS);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_MERGE = 5'b01000,
        ST_DRAIN = 5'b10000
    } t_state;

    function automatic dmx_psm_pkg::t_cmd t_cmd_cast(input logic [dmx_psm_pkg::CMD_W-1:0] c);
        return dmx_psm_pkg::t_cmd'(c);
    endfunction

    t_state r_state, n_state;

    logic          r_mode;
    logic [TW-1:0] r_timeout;

    logic [SOURCES-1:0] r_set;
    logic [PW-1:0]      r_prio  [SOURCES];
    logic [TW-1:0]      r_stamp [SOURCES];
    logic [LW-1:0]      r_len   [SOURCES];

    logic [PW-1:0] r_wprio, n_wprio;
    logic [LW-1:0] r_olen, n_olen;

    logic          r_ovalid, n_ovalid;
    logic [VW-1:0] r_rval, n_rval;
    logic          r_changed, n_changed;
    logic          r_noact, n_noact;

    logic [SW-1:0] r_cs;
    logic [TW-1:0] r_now;
    logic [CHIN_WL-1:0] r_rch;

    logic [SW-1:0]      r_sc, n_sc;
    logic [PW-1:0]      r_lvl, n_lvl;
    logic [SOURCES-1:0] r_mask, n_mask;
    logic               r_any, n_any;
    logic               r_multi, n_multi;
    logic               r_csin, n_csin;
    logic [LW-1:0]      r_maxlen, n_maxlen;

    logic [SW-1:0] r_ms, n_ms;
    logic [CW-1:0] r_mi, n_mi;
    logic          r_rdv, n_rdv;
    logic [SW-1:0] r_ms_d;
    logic [CW-1:0] r_mi_d;
    logic [VW-1:0] r_acc, n_acc;

    logic          accept;
    logic          src_ok;
    logic          commit_acc;
    logic [SW-1:0] src_w;
    logic [SW-1:0] hidx;
    logic          act;
    logic [TW-1:0] age;
    logic [PW-1:0] prio_sat;
    logic [LW-1:0] len_sat;
    logic          src_we;
    logic [SW+CW-1:0] src_waddr, src_raddr;
    logic [VW-1:0] src_rdata, out_rdata, vsel, vmax;
    logic          out_we;
    logic [CW-1:0] out_raddr;
    logic [CW-1:0] last_ch;
    logic          grp_end;

    assign o_ready = (r_state == ST_IDLE) && (!r_ovalid || i_ready);
    assign accept  = i_valid && o_ready;
    assign src_ok  = {{(32-dmx_psm_pkg::SRCIN_W){1'b0}}, i_source_index} < 32'(SOURCES);
    assign src_w   = SW'(i_source_index);
    assign commit_acc = accept && src_ok
                        && (t_cmd_cast(i_command) == dmx_psm_pkg::CMD_COMMIT);
    assign prio_sat = (i_priority_req > dmx_psm_pkg::PRIO_MAX) ? dmx_psm_pkg::PRIO_MAX
                                                               : i_priority_req;
    assign len_sat  = (i_frame_length > CH_MAX) ? CH_MAX : i_frame_length;

    // source RAM
    assign src_we    = accept && (t_cmd_cast(i_command) == dmx_psm_pkg::CMD_WRITE) && src_ok
                       && ({1'b0, i_channel} < CH_MAX);
    assign src_waddr = {src_w, CW'(i_channel)};
    assign src_raddr = {r_ms, r_mi};

    dmx_psm_ram #(.WIDTH(VW), .DEPTH(SRC_DEPTH)) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (src_we),
        .i_waddr (src_waddr),
        .i_wdata (i_value),
        .i_raddr (src_raddr),
        .o_rdata (src_rdata)
    );

    // header view
    assign hidx = (r_state == ST_SCAN) ? r_sc : r_ms_d;
    assign age  = r_now - r_stamp[hidx];
    assign act  = r_set[hidx] && (r_len[hidx] != '0) && (age < r_timeout);

    // merge datapath
    assign last_ch = CW'(r_olen - LW'(1));
    assign vsel    = (r_mask[r_ms_d] && (LW'(r_mi_d) < r_len[r_ms_d])) ? src_rdata : '0;
    assign vmax    = (r_ms_d == '0) ? vsel : ((vsel > r_acc) ? vsel : r_acc);
    assign grp_end = r_rdv && (r_ms_d == LAST_SRC);
    assign out_we  = grp_end;
    assign out_raddr = CW'(i_channel);

    dmx_psm_ram #(.WIDTH(VW), .DEPTH(OUT_DEPTH)) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (out_we),
        .i_waddr (r_mi_d),
        .i_wdata (vmax),
        .i_raddr (out_raddr),
        .o_rdata (out_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_wprio   = r_wprio;
        n_olen    = r_olen;
        n_ovalid  = r_ovalid && !i_ready;
        n_rval    = r_rval;
        n_changed = r_changed;
        n_noact   = r_noact;
        n_sc      = r_sc;
        n_lvl     = r_lvl;
        n_mask    = r_mask;
        n_any     = r_any;
        n_multi   = r_multi;
        n_csin    = r_csin;
        n_maxlen  = r_maxlen;
        n_ms      = r_ms;
        n_mi      = r_mi;
        n_rdv     = 1'b0;
        n_acc     = vmax;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_rval    = '0;
                    n_changed = 1'b0;
                    n_noact   = 1'b0;
                    case (t_cmd_cast(i_command))
                        dmx_psm_pkg::CMD_READ: begin
                            n_state = ST_READ;
                        end
                        dmx_psm_pkg::CMD_COMMIT: begin
                            if (src_ok) begin
                                n_state  = ST_SCAN;
                                n_sc     = '0;
                                n_lvl    = '0;
                                n_mask   = '0;
                                n_any    = 1'b0;
                                n_multi  = 1'b0;
                                n_csin   = 1'b0;
                                n_maxlen = '0;
                            end else begin
                                n_ovalid = 1'b1;
                            end
                        end
                        default: begin
                            n_ovalid = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_rval   = (({1'b0, r_rch} < CH_MAX) && ({1'b0, r_rch} < r_olen))
                           ? out_rdata : '0;
                n_ovalid = 1'b1;
                n_state  = ST_IDLE;
            end
            ST_SCAN: begin
                if (act && (r_prio[hidx] > r_lvl)) begin
                    n_lvl          = r_prio[hidx];
                    n_mask         = '0;
                    n_mask[hidx]   = 1'b1;
                    n_any          = 1'b1;
                    n_multi        = 1'b0;
                    n_csin         = (hidx == r_cs);
                    n_maxlen       = r_len[hidx];
                end else if (act && (r_prio[hidx] == r_lvl)) begin
                    n_mask[hidx]   = 1'b1;
                    n_any          = 1'b1;
                    n_multi        = r_any;
                    n_csin         = r_csin || (hidx == r_cs);
                    n_maxlen       = (r_len[hidx] > r_maxlen) ? r_len[hidx] : r_maxlen;
                end
                n_sc = r_sc + SW'(1);
                if (r_sc == LAST_SRC) begin
                    n_wprio = n_lvl;
                    n_noact = !n_any;
                    if (!n_any || !n_csin) begin
                        n_ovalid = 1'b1;
                        n_state  = ST_IDLE;
                    end else begin
                        n_changed = 1'b1;
                        n_ms      = '0;
                        n_mi      = '0;
                        n_state   = ST_MERGE;
                        if (n_multi && r_mode) begin
                            n_olen = n_maxlen;
                        end else begin
                            n_mask       = '0;
                            n_mask[r_cs] = 1'b1;
                            n_olen       = r_len[r_cs];
                        end
                    end
                end
            end
            ST_MERGE: begin
                n_rdv = 1'b1;
                if (r_ms == LAST_SRC) begin
                    n_ms = '0;
                    n_mi = r_mi + CW'(1);
                    if (r_mi == last_ch) begin
                        n_state = ST_DRAIN;
                    end
                end else begin
                    n_ms = r_ms + SW'(1);
                end
            end
            ST_DRAIN: begin
                if (grp_end && (r_mi_d == last_ch)) begin
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_mode    <= 1'b0;
            r_timeout <= dmx_psm_pkg::TIMEOUT_DEFAULT;
            r_set     <= '0;
            r_wprio   <= '0;
            r_olen    <= '0;
            r_ovalid  <= 1'b0;
            r_rdv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wprio  <= n_wprio;
            r_olen   <= n_olen;
            r_ovalid <= n_ovalid;
            r_rdv    <= n_rdv;
            if (i_cfg_we) begin
                if (i_cfg_index == dmx_psm_pkg::CFG_MODE) begin
                    r_mode <= i_cfg_data[0];
                end else begin
                    r_timeout <= i_cfg_data;
                end
            end
            if (accept && src_ok) begin
                if (t_cmd_cast(i_command) == dmx_psm_pkg::CMD_COMMIT) begin
                    r_set[src_w] <= 1'b1;
                end else if (t_cmd_cast(i_command) == dmx_psm_pkg::CMD_REMOVE) begin
                    r_set[src_w] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SOURCES; s++) begin
                r_prio[s]  <= '0;
                r_len[s]   <= '0;
                r_stamp[s] <= '0;
            end
        end else if (commit_acc) begin
            r_prio[src_w]  <= prio_sat;
            r_len[src_w]   <= len_sat;
            r_stamp[src_w] <= i_now_time;
        end
        if (accept) begin
            r_cs  <= src_w;
            r_now <= i_now_time;
            r_rch <= i_channel;
        end
        r_rval    <= n_rval;
        r_changed <= n_changed;
        r_noact   <= n_noact;
        r_sc      <= n_sc;
        r_lvl     <= n_lvl;
        r_mask    <= n_mask;
        r_any     <= n_any;
        r_multi   <= n_multi;
        r_csin    <= n_csin;
        r_maxlen  <= n_maxlen;
        r_ms      <= n_ms;
        r_mi      <= n_mi;
        r_ms_d    <= r_ms;
        r_mi_d    <= r_mi;
        r_acc     <= n_acc;
    end

    assign o_valid         = r_ovalid;
    assign o_read_value    = r_rval;
    assign o_changed       = r_changed;
    assign o_no_active     = r_noact;
    assign o_active_level  = r_wprio;
    assign o_merged_length = r_olen;

    `DMX_PSM_ASSERT_NOW(a_out_write_in_merge, out_we, (r_state == ST_MERGE) || (r_state == ST_DRAIN))
    `DMX_PSM_ASSERT_NOW(a_changed_has_winner, r_ovalid && r_changed, !r_noact && (r_olen != '0))
    `DMX_PSM_ASSERT_NEXT(a_commit_starts_scan, commit_acc, r_state == ST_SCAN)

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dmx_priority_source_merger. A directed table walks
// reset state, saturation, zero length, LTP ties, timeouts and time wrap,
// then random frame writes and commits run under several mode and timeout
// settings, each result checked by the merge predictor or a row's expectation.
// ----------------------------------------------------------------------------
module tb;
    import dmx_psm_pkg::*;

    localparam int NSRC = 8;
    localparam int NCH  = 512;

    typedef struct packed {
        logic [LVL_W-1:0]  rd;
        logic              chg;
        logic              none;
        logic [PRIO_W-1:0] lvl;
        logic [LEN_W-1:0]  len;
    } t_merge_res;

    typedef struct {
        t_cmd               cmd;
        logic [2:0]         src;
        logic [8:0]         ch;
        logic [7:0]         val;
        logic [7:0]         prio;
        logic [9:0]         len;
        logic [31:0]        now;
        bit                 chk;
        t_merge_res         res;
    } t_stim;

    logic i_clk, i_rst_n, i_valid, o_ready, i_ready, o_valid;
    logic [CMD_W-1:0]   i_command;
    logic [2:0]         i_source_index;
    logic [8:0]         i_channel;
    logic [7:0]         i_value, i_priority_req, o_read_value, o_active_level;
    logic [9:0]         i_frame_length, o_merged_length;
    logic [31:0]        i_now_time, i_cfg_data;
    logic               o_changed, o_no_active, i_cfg_we, i_cfg_index;

    dmx_priority_source_merger dut (.*);

    // predictor state
    bit          m_set   [NSRC];
    logic [7:0]  m_prio  [NSRC];
    logic [31:0] m_stamp [NSRC];
    logic [9:0]  m_len   [NSRC];
    logic [7:0]  m_lvls  [NSRC][NCH];
    logic [7:0]  m_out   [NCH];
    logic [9:0]  m_out_len;
    logic [7:0]  m_win;
    logic        m_mode;
    logic [31:0] m_tmo;

    bit          written [NSRC][NCH];
    t_merge_res  merge_q[$];
    int          errors, n_acc, tx_idle, rx_idle;
    bit          cur_chk;
    t_merge_res  cur_res;
    logic [31:0] tnow;
    t_stim       stim_rows[$];

    function automatic void add_row(t_stim t);
        stim_rows = {stim_rows, t};
    endfunction

    function automatic void copy_frame(int s);
        for (int i = 0; i < NCH; i++) m_out[i] = (i < m_len[s]) ? m_lvls[s][i] : 8'd0;
        m_out_len = m_len[s];
    endfunction

    function automatic bit run_merge(int cs, logic [31:0] now, output bit none);
        bit          win [NSRC];
        int          cnt;
        bit          cs_in;
        logic [7:0]  lvl;
        logic [31:0] age, my_age;
        cnt = 0; cs_in = 0; lvl = 0;
        for (int s = 0; s < NSRC; s++) begin
            win[s] = 0;
            age = now - m_stamp[s];
            if (!(m_set[s] && m_len[s] != 0 && age < m_tmo)) continue;
            if (m_prio[s] > lvl) begin
                lvl = m_prio[s];
                for (int i = 0; i < s; i++) win[i] = 0;
                cnt = 0;
                cs_in = 0;
            end
            if (m_prio[s] == lvl) begin
                win[s] = 1;
                cnt++;
                if (s == cs) cs_in = 1;
            end
        end
        m_win = lvl;
        none = (cnt == 0);
        if (cnt == 0 || !cs_in) return 0;
        if (cnt == 1) begin
            copy_frame(cs);
        end else if (m_mode == 1'b0) begin
            my_age = now - m_stamp[cs];
            for (int s = 0; s < NSRC; s++) begin
                age = now - m_stamp[s];
                if (win[s] && age < my_age) return 0;
            end
            copy_frame(cs);
        end else begin
            for (int i = 0; i < NCH; i++) m_out[i] = 0;
            m_out_len = 0;
            for (int s = 0; s < NSRC; s++) begin
                if (!win[s]) continue;
                for (int i = 0; i < m_len[s]; i++)
                    if (m_lvls[s][i] > m_out[i]) m_out[i] = m_lvls[s][i];
                if (m_len[s] > m_out_len) m_out_len = m_len[s];
            end
        end
        return 1;
    endfunction

    function automatic t_merge_res merger_step(t_cmd cmd, int src, int ch, logic [7:0] val,
                                               logic [7:0] prio, logic [9:0] len,
                                               logic [31:0] now);
        t_merge_res r;
        bit none;
        r = '0;
        none = 0;
        case (cmd)
            CMD_WRITE: m_lvls[src][ch] = val;
            CMD_COMMIT: begin
                m_set[src]   = 1;
                m_prio[src]  = (prio > PRIO_MAX) ? PRIO_MAX : prio;
                m_len[src]   = (len > NCH) ? 10'(NCH) : len;
                m_stamp[src] = now;
                r.chg = run_merge(src, now, none);
            end
            CMD_READ: if (ch < m_out_len) r.rd = m_out[ch];
            default: m_set[src] = 0;
        endcase
        r.none = none;
        r.lvl  = m_win;
        r.len  = m_out_len;
        return r;
    endfunction

    function automatic int filled_prefix(int s);
        for (int i = 0; i < NCH; i++) if (!written[s][i]) return i;
        return NCH;
    endfunction

    function automatic t_stim mk(t_cmd cmd, int src, int ch, int val, int prio, int len,
                                 logic [31:0] now);
        t_stim t;
        t.cmd = cmd; t.src = 3'(src); t.ch = 9'(ch); t.val = 8'(val); t.prio = 8'(prio);
        t.len = 10'(len);
        t.now = now; t.chk = 0; t.res = '0;
        return t;
    endfunction

    function automatic t_stim mkc(t_cmd cmd, int src, int ch, int val, int prio, int len,
                                  logic [31:0] now, t_merge_res res);
        t_stim t;
        t = mk(cmd, src, ch, val, prio, len, now);
        t.chk = 1;
        t.res = res;
        return t;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("dmx_priority_source_merger: mismatch");
        $finish;
    end

    initial begin
        i_ready = 0;
        forever begin
            @(negedge i_clk);
            i_ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin
        t_merge_res r, e;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                r = merger_step(t_cmd'(i_command), i_source_index, i_channel, i_value,
                                i_priority_req, i_frame_length, i_now_time);
                merge_q = {merge_q, (cur_chk ? cur_res : r)};
                n_acc++;
            end
            if (o_valid && i_ready) begin
                if (merge_q.size() == 0) begin
                    $error("result transfer with no expectation");
                    errors++;
                end else begin
                    e = merge_q.pop_front();
                    if (o_read_value !== e.rd) begin
                        $error("read_value exp %0d got %0d", e.rd, o_read_value);
                        errors++;
                    end
                    if (o_changed !== e.chg) begin
                        $error("changed exp %0d got %0d", e.chg, o_changed);
                        errors++;
                    end
                    if (o_no_active !== e.none) begin
                        $error("no_active exp %0d got %0d", e.none, o_no_active);
                        errors++;
                    end
                    if (o_active_level !== e.lvl) begin
                        $error("active_level exp %0d got %0d", e.lvl, o_active_level);
                        errors++;
                    end
                    if (o_merged_length !== e.len) begin
                        $error("merged_length exp %0d got %0d", e.len, o_merged_length);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic send(t_stim t);
        int target;
        while ($urandom_range(0, 99) < tx_idle) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_command      <= t.cmd;
        i_source_index <= t.src;
        i_channel      <= t.ch;
        i_value        <= t.val;
        i_priority_req <= t.prio;
        i_frame_length <= t.len;
        i_now_time     <= t.now;
        cur_chk        <= t.chk;
        cur_res        <= t.res;
        i_valid        <= 1;
        if (t.cmd == CMD_WRITE) written[t.src][t.ch] = 1;
        target = n_acc + 1;
        do @(negedge i_clk); while (n_acc < target);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (merge_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_reg(logic idx, logic [31:0] data);
        i_cfg_we    <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 0;
    endtask

    task automatic send_random();
        t_stim t;
        int    s, p, k;
        s = $urandom_range(0, NSRC - 1);
        p = filled_prefix(s);
        t = mk(t_cmd'($urandom_range(0, 3)), s, $urandom_range(0, NCH - 1),
               $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1023), 0);
        k = $urandom_range(0, 99);
        case ($urandom_range(0, 2))
            0: tnow = tnow + $urandom_range(0, 400);
            1: tnow = tnow + $urandom_range(0, 40);
            default: if ($urandom_range(0, 19) == 0) tnow = $urandom;
                     else if ($urandom_range(0, 9) == 0) tnow = tnow - $urandom_range(0, 50);
        endcase
        t.now = tnow;
        if (k < 55) begin
            t.cmd = CMD_WRITE;
            if (p < 24 && $urandom_range(0, 3) != 0) t.ch = 9'(p);
            else if ($urandom_range(0, 1) == 0 && p > 0) t.ch = 9'($urandom_range(0, p - 1));
        end else if (k < 80) begin
            t.cmd = CMD_COMMIT;
            if ($urandom_range(0, 9) < 7) t.prio = 8'($urandom_range(0, 4) * 50);
            if (p == NCH && $urandom_range(0, 9) == 0) t.len = 10'($urandom_range(NCH, 1023));
            else t.len = 10'($urandom_range(0, (p > 24) ? 24 : p));
        end else if (k < 94) begin
            t.cmd = CMD_READ;
            if ($urandom_range(0, 3) != 0) t.ch = 9'($urandom_range(0, 30));
        end else begin
            t.cmd = CMD_REMOVE;
        end
        send(t);
    endtask

    initial begin
        t_merge_res z;
        int         total;
        errors = 0; n_acc = 0; tx_idle = 27; rx_idle = 55;
        i_rst_n = 0; i_valid = 0; i_command = 0; i_source_index = 0; i_channel = 0;
        i_value = 0; i_priority_req = 0; i_frame_length = 0; i_now_time = 0;
        i_cfg_we = 0; i_cfg_index = 0; i_cfg_data = 0;
        cur_chk = 0; cur_res = '0;
        m_mode = 0; m_tmo = TIMEOUT_DEFAULT; m_out_len = 0; m_win = 0;
        for (int s = 0; s < NSRC; s++) begin
            m_set[s] = 0; m_prio[s] = 0; m_stamp[s] = 0; m_len[s] = 0;
            for (int i = 0; i < NCH; i++) begin
                m_lvls[s][i] = 0;
                written[s][i] = 0;
            end
        end
        for (int i = 0; i < NCH; i++) m_out[i] = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        z = '0;
        add_row(mkc(CMD_READ, 0, 0, 0, 0, 0, 0, z));
        add_row(mkc(CMD_READ, 0, 511, 0, 0, 0, 0, z));
        add_row(mkc(CMD_COMMIT, 0, 0, 0, 100, 0, 10, '{0, 0, 1, 0, 0}));
        add_row(mk(CMD_WRITE, 1, 0, 255, 0, 0, 11));
        add_row(mk(CMD_WRITE, 1, 1, 0, 0, 0, 12));
        add_row(mk(CMD_WRITE, 1, 2, 8'h5A, 0, 0, 13));
        add_row(mkc(CMD_COMMIT, 1, 0, 0, 255, 3, 20, '{0, 1, 0, 200, 3}));
        add_row(mkc(CMD_READ, 0, 0, 0, 0, 0, 21, '{255, 0, 0, 200, 3}));
        add_row(mkc(CMD_READ, 0, 2, 0, 0, 0, 22, '{8'h5A, 0, 0, 200, 3}));
        add_row(mkc(CMD_READ, 0, 3, 0, 0, 0, 23, '{0, 0, 0, 200, 3}));
        add_row(mk(CMD_WRITE, 2, 0, 7, 0, 0, 24));
        add_row(mk(CMD_WRITE, 2, 1, 8'h80, 0, 0, 25));
        add_row(mk(CMD_COMMIT, 2, 0, 0, 200, 2, 30));
        add_row(mk(CMD_COMMIT, 1, 0, 0, 200, 3, 5000));
        add_row(mk(CMD_COMMIT, 2, 0, 0, 50, 2, 5001));
        add_row(mk(CMD_REMOVE, 1, 0, 0, 0, 0, 5001));
        add_row(mk(CMD_COMMIT, 2, 0, 0, 50, 2, 5002));
        add_row(mk(CMD_COMMIT, 2, 0, 0, 50, 2, 32'hFFFF_FFF0));
        add_row(mk(CMD_COMMIT, 1, 0, 0, 50, 3, 32'h0000_0010));
        add_row(mk(CMD_READ, 0, 1, 0, 0, 0, 32'h0000_0010));
        add_row(mk(CMD_WRITE, 3, 0, 8'hA5, 0, 0, 32'h0000_0011));
        add_row(mk(CMD_COMMIT, 3, 0, 0, 201, 1, 32'h0000_0011));
        add_row(mk(CMD_READ, 0, 500, 0, 0, 0, 32'hFFFF_FFFF));
        foreach (stim_rows[i]) send(stim_rows[i]);
        drain();

        total = stim_rows.size();
        tnow = $urandom;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin set_reg(CFG_MODE, 0); set_reg(CFG_TIMEOUT, 1500); end
                1: begin
                    set_reg(CFG_MODE, 1); set_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
                    tx_idle = 55; rx_idle = 27;
                end
                2: begin set_reg(CFG_MODE, 0); set_reg(CFG_TIMEOUT, 0); end
                default: begin
                    set_reg(CFG_MODE, 1); set_reg(CFG_TIMEOUT, 300);
                    tx_idle = 0; rx_idle = 0;
                end
            endcase
            m_mode = (ph == 1 || ph == 3);
            m_tmo  = (ph == 0) ? 1500 : (ph == 1) ? 32'hFFFF_FFFF : (ph == 2) ? 0 : 300;
            if (ph == 1) begin
                for (int i = 0; i < NCH; i++)
                    send(mk(CMD_WRITE, 7, i, $urandom_range(0, 255), 0, 0, tnow));
                send(mk(CMD_COMMIT, 7, 0, 0, 200, 1023, tnow));
                send(mk(CMD_COMMIT, 7, 0, 0, 200, 513, tnow + 1));
                total += NCH + 2;
            end
            for (int n = 0; n < ((ph == 2) ? 60 : 150); n++) begin
                send_random();
                total++;
            end
            if (ph == 3) while (total < 1050) begin
                send_random();
                total++;
            end
            drain();
        end

        repeat (20) @(negedge i_clk);
        if (errors == 0 && merge_q.size() == 0) begin
            $display("dmx_priority_source_merger: match");
        end else begin
            $display("dmx_priority_source_merger: mismatch");
        end
        $finish;
    end

endmodule

### dmx_priority_source_merger.f
+incdir+design
design/dmx_psm_pkg.sv
design/dmx_psm_ram.sv
design/dmx_priority_source_merger.sv
sim/tb.sv
